[src/absel_pkg.sv]
`default_nettype none

package absel_pkg;

	localparam logic [2:0] MODE_BEGIN = 3'd0;
	localparam logic [2:0] MODE_DATA = 3'd1;
	localparam logic [2:0] MODE_END = 3'd2;
	localparam logic [2:0] MODE_LOAD = 3'd3;
	localparam logic [2:0] MODE_SAVE = 3'd4;

	localparam logic [1:0] ACC_READABLE = 2'd0;
	localparam logic [1:0] ACC_NOT_FOUND = 2'd1;
	localparam logic [1:0] ACC_OPEN_FAILED = 2'd2;
	localparam logic [1:0] ACC_READ_FAILED = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_OPEN_FAILED = 3'd1;
	localparam logic [2:0] ST_READ_FAILED = 3'd2;
	localparam logic [2:0] ST_CRC_FAILED = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	localparam logic [1:0] KIND_VERDICT = 2'd0;
	localparam logic [1:0] KIND_LOAD = 2'd1;
	localparam logic [1:0] KIND_SAVE = 2'd2;

	localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

	localparam logic [31:0] NIB_TAB [16] = '{
		32'h00000000, 32'h1DB71064, 32'h3B6E20C8, 32'h26D930AC,
		32'h76DC4190, 32'h6B6B51F4, 32'h4DB26158, 32'h5005713C,
		32'hEDB88320, 32'hF00F9344, 32'hD6D6A3E8, 32'hCB61B38C,
		32'h9B64C2B0, 32'h86D3D2D4, 32'hA00AE278, 32'hBDBDF21C
	};

	typedef struct packed {
		logic [2:0] mode;
		logic slot;
		logic [7:0] byte_value;
		logic [31:0] seed_sequence;
		logic [1:0] access_status;
		logic [31:0] record_crc;
	} req_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic slot_choice;
		logic [2:0] status;
		logic [31:0] computed_crc;
		logic [31:0] next_sequence;
		logic target_valid;
	} res_t;

endpackage

`default_nettype wire

[src/absel_crc.sv]
`default_nettype none

module absel_crc (
	input wire logic [31:0] crc_in,
	input wire logic [7:0] byte_value,
	output logic [31:0] crc_out
);
	import absel_pkg::*;

	logic [31:0] mid;

	always_comb begin
		mid = (crc_in >> 4) ^ NIB_TAB[crc_in[3:0] ^ byte_value[3:0]];
		crc_out = (mid >> 4) ^ NIB_TAB[mid[3:0] ^ byte_value[7:4]];
	end

endmodule

`default_nettype wire

[src/absel_engine.sv]
`default_nettype none

module absel_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire absel_pkg::req_t req,
	output logic has_res,
	output absel_pkg::res_t res
);
	import absel_pkg::*;

	logic [31:0] crc_q;
	logic open_slot_q;
	logic [1:0] open_status_q;
	logic [2:0] verdict_q [2];
	logic [31:0] seq_q [2];

	logic [31:0] crc_next;
	logic [2:0] end_verdict;
	logic [31:0] diff_ba;
	logic b_newer;

	absel_crc u_crc (
		.crc_in(crc_q),
		.byte_value(req.byte_value),
		.crc_out(crc_next)
	);

	always_comb begin
		diff_ba = seq_q[1] - seq_q[0];
		b_newer = (diff_ba != 32'd0) && (diff_ba < HALF_RANGE);

		case (open_status_q)
			ACC_READABLE: end_verdict = (crc_q == req.record_crc) ? ST_OK : ST_CRC_FAILED;
			ACC_NOT_FOUND: end_verdict = ST_NOT_FOUND;
			ACC_OPEN_FAILED: end_verdict = ST_OPEN_FAILED;
			default: end_verdict = ST_READ_FAILED;
		endcase

		res = '0;
		has_res = 1'b0;
		case (req.mode)
			MODE_END: begin
				has_res = 1'b1;
				res.result_kind = KIND_VERDICT;
				res.slot_choice = open_slot_q;
				res.status = end_verdict;
				res.computed_crc = crc_q;
			end
			MODE_LOAD: begin
				has_res = 1'b1;
				res.result_kind = KIND_LOAD;
				if (verdict_q[1] == ST_OK && (verdict_q[0] != ST_OK || b_newer)) begin
					res.slot_choice = 1'b1;
					res.status = ST_OK;
					res.target_valid = 1'b1;
				end else if (verdict_q[0] == ST_NOT_FOUND) begin
					res.status = verdict_q[1];
				end else begin
					res.status = verdict_q[0];
					res.target_valid = (verdict_q[0] == ST_OK);
				end
			end
			MODE_SAVE: begin
				has_res = 1'b1;
				res.result_kind = KIND_SAVE;
				if (verdict_q[0] == ST_OK && (verdict_q[1] != ST_OK || !b_newer)) begin
					res.slot_choice = 1'b1;
					res.status = ST_OK;
					res.next_sequence = seq_q[0] + 32'd1;
					res.target_valid = 1'b1;
				end else if (verdict_q[1] == ST_OK) begin
					res.status = ST_OK;
					res.next_sequence = seq_q[1] + 32'd1;
					res.target_valid = 1'b1;
				end else if (verdict_q[0] == ST_NOT_FOUND && verdict_q[1] == ST_NOT_FOUND) begin
					res.status = ST_OK;
					res.next_sequence = 32'd1;
					res.target_valid = 1'b1;
				end else begin
					res.status = (verdict_q[0] != ST_NOT_FOUND) ? verdict_q[0] : verdict_q[1];
				end
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			open_slot_q <= 1'b0;
			open_status_q <= ACC_READABLE;
			verdict_q[0] <= ST_NOT_FOUND;
			verdict_q[1] <= ST_NOT_FOUND;
			seq_q[0] <= '0;
			seq_q[1] <= '0;
		end else if (fire) begin
			case (req.mode)
				MODE_BEGIN: begin
					open_slot_q <= req.slot;
					open_status_q <= req.access_status;
					seq_q[req.slot] <= req.seed_sequence;
					crc_q <= ~req.seed_sequence;
				end
				MODE_DATA: begin
					crc_q <= crc_next;
				end
				MODE_END: begin
					verdict_q[open_slot_q] <= end_verdict;
				end
				default: begin
				end
			endcase
		end
	end

	a_begin_seeds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.mode == MODE_BEGIN |=> crc_q == ~$past(req.seed_sequence))
		else $error("CRC not seeded from inverted sequence");

	a_data_advances: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.mode == MODE_DATA |=> crc_q == $past(crc_next))
		else $error("CRC not advanced by data byte");

	a_end_records: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.mode == MODE_END |=> verdict_q[$past(open_slot_q)] == $past(res.status))
		else $error("slot verdict not recorded at end of record");

endmodule

`default_nettype wire

[src/ab_slot_crc_record_selector.sv]
`default_nettype none
// A request is registered when accepted and evaluated once no stalled result blocks it.
// A result is held in the response register before it appears on the response port.
// One request per cycle is sustained while no stalled response blocks a result; the two
// chained CRC nibble lookups and the decision compare form the single stage between registers.
// Reset clears the CRC, the open slot, both verdicts (to not found) and sequences.

module ab_slot_crc_record_selector (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic [2:0] mode,
	input wire logic slot,
	input wire logic [7:0] byte_value,
	input wire logic [31:0] seed_sequence,
	input wire logic [1:0] access_status,
	input wire logic [31:0] record_crc,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output logic [1:0] result_kind,
	output logic slot_choice,
	output logic [2:0] status,
	output logic [31:0] computed_crc,
	output logic [31:0] next_sequence,
	output logic target_valid
);
	import absel_pkg::*;

	req_t req_s1;
	logic valid_s1;
	res_t res_q;
	logic rsp_valid_q;

	res_t res_s1;
	logic has_res_s1;
	logic advance;
	logic fire;
	logic accept;

	assign advance = !(has_res_s1 && rsp_valid_q && rsp_stall);
	assign fire = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;
	assign accept = req_valid && !req_stall;

	absel_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.req(req_s1),
		.has_res(has_res_s1),
		.res(res_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= '{mode: mode, slot: slot, byte_value: byte_value,
				seed_sequence: seed_sequence, access_status: access_status,
				record_crc: record_crc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire && has_res_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res_s1) begin
			res_q <= res_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign result_kind = res_q.result_kind;
	assign slot_choice = res_q.slot_choice;
	assign status = res_q.status;
	assign computed_crc = res_q.computed_crc;
	assign next_sequence = res_q.next_sequence;
	assign target_valid = res_q.target_valid;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && has_res_s1 && rsp_valid_q)
		else $error("request stalled without a blocked result");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire && has_res_s1 |=> rsp_valid_q)
		else $error("evaluated result did not reach the response register");

	a_silent_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid_q && !(fire && has_res_s1) |=> !rsp_valid_q)
		else $error("response appeared without an evaluated result");

endmodule

`default_nettype wire

[bench/slot_select_checker.sv]
`timescale 1ns / 100ps

module slot_select_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic [2:0] mode,
	input wire logic slot,
	input wire logic [7:0] byte_value,
	input wire logic [31:0] seed_sequence,
	input wire logic [1:0] access_status,
	input wire logic [31:0] record_crc,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire logic [1:0] result_kind,
	input wire logic slot_choice,
	input wire logic [2:0] status,
	input wire logic [31:0] computed_crc,
	input wire logic [31:0] next_sequence,
	input wire logic target_valid,
	output int fails,
	output int waiting
);
	import absel_pkg::*;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	logic [31:0] crc_acc;
	logic cur_slot;
	logic [1:0] cur_access;
	logic [2:0] verdict [2];
	logic [31:0] seq_of [2];
	res_t expected_results [$];

	function automatic logic [31:0] crc_nibble(input logic [31:0] crc, input logic [3:0] nib);
		logic [31:0] c;
		c = crc ^ {28'd0, nib};
		for (int i = 0; i < 4; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Wraparound-safe test that sequence a was written after sequence b.
	function automatic logic seq_newer(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d != 32'd0) && (d < HALF_RANGE);
	endfunction

	task automatic predict_request();
		res_t r;
		logic [2:0] va;
		logic [2:0] vb;
		logic [31:0] sa;
		logic [31:0] sb;
		va = verdict[0];
		vb = verdict[1];
		sa = seq_of[0];
		sb = seq_of[1];
		r = '0;
		case (mode)
			MODE_BEGIN: begin
				cur_slot = slot;
				cur_access = access_status;
				seq_of[slot] = seed_sequence;
				crc_acc = ~seed_sequence;
			end
			MODE_DATA: begin
				crc_acc = crc_nibble(crc_nibble(crc_acc, byte_value[3:0]), byte_value[7:4]);
			end
			MODE_END: begin
				case (cur_access)
					ACC_READABLE: r.status = (crc_acc == record_crc) ? ST_OK : ST_CRC_FAILED;
					ACC_NOT_FOUND: r.status = ST_NOT_FOUND;
					ACC_OPEN_FAILED: r.status = ST_OPEN_FAILED;
					default: r.status = ST_READ_FAILED;
				endcase
				verdict[cur_slot] = r.status;
				r.result_kind = KIND_VERDICT;
				r.slot_choice = cur_slot;
				r.computed_crc = crc_acc;
				expected_results.push_back(r);
			end
			MODE_LOAD: begin
				r.result_kind = KIND_LOAD;
				if (vb == ST_OK && (va != ST_OK || seq_newer(sb, sa))) begin
					r.slot_choice = 1'b1;
					r.status = ST_OK;
					r.target_valid = 1'b1;
				end else if (va == ST_NOT_FOUND) begin
					r.status = vb;
				end else begin
					r.status = va;
					r.target_valid = (va == ST_OK);
				end
				expected_results.push_back(r);
			end
			MODE_SAVE: begin
				r.result_kind = KIND_SAVE;
				if (va == ST_OK && (vb != ST_OK || !seq_newer(sb, sa))) begin
					r.slot_choice = 1'b1;
					r.status = ST_OK;
					r.next_sequence = sa + 32'd1;
					r.target_valid = 1'b1;
				end else if (vb == ST_OK) begin
					r.status = ST_OK;
					r.next_sequence = sb + 32'd1;
					r.target_valid = 1'b1;
				end else if (va == ST_NOT_FOUND && vb == ST_NOT_FOUND) begin
					r.status = ST_OK;
					r.next_sequence = 32'd1;
					r.target_valid = 1'b1;
				end else begin
					r.status = (va != ST_NOT_FOUND) ? va : vb;
				end
				expected_results.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			crc_acc = '0;
			cur_slot = 1'b0;
			cur_access = ACC_READABLE;
			verdict[0] = ST_NOT_FOUND;
			verdict[1] = ST_NOT_FOUND;
			seq_of[0] = '0;
			seq_of[1] = '0;
			expected_results.delete();
			fails = 0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_request();
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					$error("result arrived with no request pending");
					fails++;
				end else begin
					want = expected_results.pop_front();
					compare_field("result_kind", 32'(want.result_kind), 32'(result_kind));
					compare_field("slot_choice", 32'(want.slot_choice), 32'(slot_choice));
					compare_field("status", 32'(want.status), 32'(status));
					compare_field("computed_crc", want.computed_crc, computed_crc);
					compare_field("next_sequence", want.next_sequence, next_sequence);
					compare_field("target_valid", 32'(want.target_valid), 32'(target_valid));
				end
			end
		end
		waiting = expected_results.size();
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
	import absel_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 2025;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [2:0] mode = MODE_BEGIN;
	logic slot = 1'b0;
	logic [7:0] byte_value = '0;
	logic [31:0] seed_sequence = '0;
	logic [1:0] access_status = ACC_READABLE;
	logic [31:0] record_crc = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [1:0] result_kind;
	logic slot_choice;
	logic [2:0] status;
	logic [31:0] computed_crc;
	logic [31:0] next_sequence;
	logic target_valid;

	int fails;
	int waiting;
	int cycles = 0;
	int sent = 0;
	logic idle_on = 1'b1;
	logic [31:0] crc_mirror = '0;
	logic [31:0] last_seq = '0;

	always #6 clk = ~clk;

	ab_slot_crc_record_selector i_dut (.*);

	slot_select_checker i_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int hold;
		forever begin
			hold = idle_on ? $urandom_range(0, 3) : 0;
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	function automatic logic [31:0] byte_crc(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Sequence numbers cluster around the last one so that the newer test
	// is exercised at its wraparound boundaries.
	function automatic logic [31:0] pick_seq(input logic [31:0] near);
		case ($urandom_range(0, 7))
			0: return near;
			1: return near + 32'd1;
			2: return near - 32'd1;
			3: return near + HALF_RANGE;
			4: return near + HALF_RANGE - 32'd1;
			5: return near + 32'($urandom_range(2, 40));
			6: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
			default: return $urandom;
		endcase
	endfunction

	task automatic put_req(input logic [2:0] m, input logic s, input logic [7:0] b,
			input logic [31:0] seq, input logic [1:0] acc, input logic [31:0] scrc);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		mode <= m;
		slot <= s;
		byte_value <= b;
		seed_sequence <= seq;
		access_status <= acc;
		record_crc <= scrc;
		do @(posedge clk); while (req_stall);
		if (m <= MODE_SAVE) begin
			sent++;
		end
	endtask

	task automatic open_rec(input logic s, input logic [31:0] seq, input logic [1:0] acc);
		crc_mirror = ~seq;
		last_seq = seq;
		put_req(MODE_BEGIN, s, 8'($urandom), seq, acc, $urandom);
	endtask

	task automatic feed(input logic [7:0] b);
		crc_mirror = byte_crc(crc_mirror, b);
		put_req(MODE_DATA, 1'($urandom), b, $urandom, 2'($urandom), $urandom);
	endtask

	task automatic close_rec(input logic good);
		logic [31:0] word;
		word = good ? crc_mirror : crc_mirror ^ (32'd1 << $urandom_range(0, 31));
		put_req(MODE_END, 1'($urandom), 8'($urandom), $urandom, 2'($urandom), word);
	endtask

	task automatic ask(input logic [2:0] m);
		put_req(m, 1'($urandom), 8'($urandom), $urandom, 2'($urandom), $urandom);
	endtask

	initial begin
		logic s;
		logic [1:0] acc;
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Decisions straight after reset, then a byte and an end with no record open.
		ask(MODE_LOAD);
		ask(MODE_SAVE);
		feed(8'h00);
		close_rec(1'b1);
		ask(3'd5);
		ask(3'd7);

		// Slot B at sequence zero is newer than slot A at the top of the range.
		open_rec(1'b0, 32'hFFFF_FFFF, ACC_READABLE);
		feed(8'hFF);
		feed(8'hA5);
		close_rec(1'b1);
		open_rec(1'b1, 32'h0000_0000, ACC_READABLE);
		feed(8'h5A);
		close_rec(1'b1);
		ask(MODE_LOAD);
		ask(MODE_SAVE);

		open_rec(1'b1, 32'h7FFF_FFFF, ACC_READABLE);
		close_rec(1'b0);
		ask(MODE_LOAD);
		open_rec(1'b0, 32'h8000_0000, ACC_NOT_FOUND);
		close_rec(1'b1);
		ask(MODE_SAVE);
		open_rec(1'b0, 32'h1234_5678, ACC_OPEN_FAILED);
		close_rec(1'b1);
		open_rec(1'b1, 32'h0000_0001, ACC_READ_FAILED);
		close_rec(1'b1);
		ask(MODE_LOAD);
		ask(MODE_SAVE);

		while (sent < ITEM_TARGET) begin
			if ($urandom_range(0, 149) == 0) begin
				idle_on = ~idle_on;
			end
			case ($urandom_range(0, 19))
				16: feed(8'($urandom));
				17: close_rec($urandom_range(0, 1) == 0);
				18: open_rec(1'($urandom), pick_seq(last_seq), 2'($urandom));
				19: ask(3'($urandom_range(5, 7)));
				13, 14: ask(MODE_LOAD);
				15: ask(MODE_SAVE);
				default: begin
					s = 1'($urandom);
					acc = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : ACC_READABLE;
					open_rec(s, pick_seq(last_seq), acc);
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 4);
					repeat (n) feed(8'($urandom));
					close_rec($urandom_range(0, 7) != 0);
				end
			endcase
		end

		req_valid <= 1'b0;
		@(posedge clk);
		wait (waiting == 0);
		repeat (6) @(posedge clk);
		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
